[rtl/awdc_pkg.sv]
// ----------------------------------------------------------------------------
// awdc_pkg: shared definitions for the window delta collision detector
// Widths, register map, reset values and the Q16 gain table for the
// windowed average.
// ----------------------------------------------------------------------------
package awdc_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int WINDOW_DEPTH_DEF = 6;
    localparam int AXES             = 3;

    localparam int Q16_FRAC  = 16;
    localparam int Q16_HALF  = 32768;
    localparam int GAIN_W    = 17;
    localparam int GAIN_IDX_W = 5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam int THRESHOLD_RESET = 16384;

    // Q16 form of (1/n + 1/max(1, n div 2)) / 2, rounded to nearest.
    function automatic logic [GAIN_W-1:0] smooth_gain(input logic [GAIN_IDX_W-1:0] n);
        logic [GAIN_W-1:0] g;
        unique case (n)
            5'd1:    g = 17'd65536;
            5'd2:    g = 17'd49152;
            5'd3:    g = 17'd43691;
            5'd4:    g = 17'd24576;
            5'd5:    g = 17'd22938;
            5'd6:    g = 17'd16384;
            5'd7:    g = 17'd15604;
            5'd8:    g = 17'd12288;
            5'd9:    g = 17'd11833;
            5'd10:   g = 17'd9830;
            5'd11:   g = 17'd9533;
            5'd12:   g = 17'd8192;
            5'd13:   g = 17'd7982;
            5'd14:   g = 17'd7022;
            5'd15:   g = 17'd6866;
            5'd16:   g = 17'd6144;
            default: g = 17'd0;
        endcase
        return g;
    endfunction

endpackage

[rtl/awdc_if.sv]
// ----------------------------------------------------------------------------
// awdc_if: sample and result channels of the window delta collision detector
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface awdc_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface awdc_result_if #(
    parameter int ENERGY_W = 36
);
    logic                valid;
    logic                ready;
    logic                collision;
    logic [ENERGY_W-1:0] change_energy;

    modport source (output valid, collision, change_energy, input ready);
    modport sink   (input valid, collision, change_energy, output ready);
endinterface

[rtl/accel_window_delta_collision.sv]
// ----------------------------------------------------------------------------
// accel_window_delta_collision: windowed average change and collision flag
//
// One three-axis sample is taken per transfer on the sample channel. It
// enters a window of the last WINDOW_DEPTH samples with a running sum per
// axis; the smoothed vector is the sum scaled by a Q16 gain that depends on
// how many samples the window holds. Each sample gives one result on the
// result channel: the squared length of the change of the smoothed vector
// since the previous sample, and a collision flag when that value exceeds
// the square of the threshold register (APB, byte address 0).
// From its transfer a sample passes the load state and, per axis, the
// multiply, round and square states until its result is loaded; the next
// sample can be taken in the cycle after that, so no new sample is taken
// while one is in progress. One multiplier is shared for the threshold
// square, the per-axis gain products and change squares, one per cycle.
// A finished result waits in an output register; the block accepts the next
// sample while it waits, and holds the following result until the receiver
// takes the first. Reset empties the window, zeroes the sums and the previous
// smoothed vector, and sets the threshold to 16384.
// ----------------------------------------------------------------------------
module accel_window_delta_collision
    import awdc_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    awdc_sample_if.sink           sample,
    awdc_result_if.source         result
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
    localparam int SM_W   = SAMPLE_BITS + 2;
    localparam int D_W    = SAMPLE_BITS + 3;
    localparam int THR_W  = SAMPLE_BITS + 1;
    localparam int EN_W   = 2 * SAMPLE_BITS + 4;
    localparam int M1_W   = (SUM_W > D_W) ? SUM_W : D_W;
    localparam int M2_W   = (M1_W > THR_W + 1) ? M1_W : THR_W + 1;
    localparam int MUL_W  = (M2_W > GAIN_W + 1) ? M2_W : GAIN_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ENT_W  = AXES * SAMPLE_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [1:0]               axis_reg, axis_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [THR_W-1:0]         thr_reg;
    logic signed [SUM_W-1:0]  sum_reg [AXES];
    logic signed [SUM_W-1:0]  sum_next [AXES];
    logic signed [SM_W-1:0]   prev_reg [AXES];
    logic signed [SAMPLE_BITS-1:0] samp_reg [AXES];
    logic [ENT_W-1:0]         win_mem [WINDOW_DEPTH];
    logic [ENT_W-1:0]         rd_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [D_W-1:0]    d_reg;
    logic [EN_W-1:0]          energy_reg, energy_next;
    logic [EN_W-1:0]          limit_reg;
    logic                     out_valid_reg;
    logic                     collision_reg;
    logic [EN_W-1:0]          out_energy_reg;

    logic                     accept;
    logic                     cfg_write;
    logic                     win_full;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SM_W-1:0]   sm;
    logic signed [D_W-1:0]    d_val;
    logic [EN_W-1:0]          en_total;
    logic                     load_out;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_THRESHOLD);
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? APB_DATA_W'(thr_reg) : '0;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid & sample.ready;

    assign result.valid         = out_valid_reg;
    assign result.collision     = collision_reg;
    assign result.change_energy = out_energy_reg;

    assign win_full = (fill_reg == CNT_W'(WINDOW_DEPTH));

    // Shared multiplier: threshold square, gain product, change square.
    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                mul_a = MUL_W'($signed({1'b0, thr_reg}));
                mul_b = MUL_W'($signed({1'b0, thr_reg}));
            end
            ST_SQR:
            begin
                mul_a = MUL_W'(d_reg);
                mul_b = MUL_W'(d_reg);
            end
            default:
            begin
                mul_a = MUL_W'(sum_reg[axis_reg]);
                mul_b = MUL_W'($signed({1'b0, gain_reg}));
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign rnd      = prod_reg + PROD_W'(Q16_HALF);
    assign sm       = rnd[Q16_FRAC +: SM_W];
    assign d_val    = D_W'(sm) - D_W'(prev_reg[axis_reg]);
    assign en_total = energy_reg + prod_reg[EN_W-1:0];
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sum_next[a] = sum_reg[a] + SUM_W'(samp_reg[a])
                        - (win_full ? SUM_W'($signed(rd_reg[a*SAMPLE_BITS +: SAMPLE_BITS]))
                                    : SUM_W'(0));
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        energy_next = energy_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                slot_next   = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                fill_next   = win_full ? fill_reg : fill_reg + 1'b1;
                energy_next = '0;
                axis_next   = '0;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                if (axis_reg != 2'd0)
                begin
                    energy_next = en_total;
                end
                state_next = ST_RND;
            end
            ST_RND:
            begin
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (axis_reg == 2'(AXES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            thr_reg       <= THR_W'(THRESHOLD_RESET);
            out_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a]  <= '0;
                prev_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
            if (cfg_write)
            begin
                thr_reg <= pwdata[THR_W-1:0];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_LOAD)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    sum_reg[a] <= sum_next[a];
                end
            end
            if (state_reg == ST_RND)
            begin
                prev_reg[axis_reg] <= sm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg[0] <= sample.accel_x;
            samp_reg[1] <= sample.accel_y;
            samp_reg[2] <= sample.accel_z;
            rd_reg      <= win_mem[slot_reg];
        end
        if (state_reg == ST_LOAD)
        begin
            win_mem[slot_reg] <= {samp_reg[2], samp_reg[1], samp_reg[0]};
            gain_reg          <= smooth_gain(GAIN_IDX_W'(fill_next));
            limit_reg         <= mul_p[EN_W-1:0];
        end
        if (state_reg == ST_MUL || state_reg == ST_SQR)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_RND)
        begin
            d_reg <= d_val;
        end
        energy_reg <= energy_next;
        if (load_out)
        begin
            collision_reg  <= (en_total > limit_reg);
            out_energy_reg <= en_total;
        end
    end

endmodule
